### rtl/ihd_pkg.sv
// ----------------------------------------------------------------------------
// ihd_pkg
// Shared constants, codes and types of the in-flight range hazard detector.
// ----------------------------------------------------------------------------
package ihd_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SECTOR_BITS = 48;
  localparam int COUNT_W     = 16;
  localparam int TAG_W       = 5;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W     = 2 * SECTOR_BITS + 1;

  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef logic [SECTOR_BITS-1:0] lba_t;
  typedef logic [IDX_W-1:0]       idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    lba_t first;
    lba_t final_sector;
    logic wr;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic race;
    logic found;
    idx_t slot;
  } scan_res_t;

endpackage

### rtl/inflight_range_hazard_detector_unit.sv
// ----------------------------------------------------------------------------
// inflight_range_hazard_detector_unit
// Flow: a submit passes S_PREP, S_SCAN and S_FINISH; a zero-length submit
//   skips S_SCAN, and a complete goes straight to S_FINISH.
// One transaction at a time: a new one is taken only in S_IDLE. The scan
//   reads one table entry per cycle through the entry RAM's single read port.
// Reset: synchronous, clears all valid bits, the offset and the handshakes.
// ----------------------------------------------------------------------------
module inflight_range_hazard_detector_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [ihd_pkg::SECTOR_BITS-1:0] cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [ihd_pkg::SECTOR_BITS-1:0] start_sector,
  input  logic [ihd_pkg::COUNT_W-1:0]     sector_count,
  input  logic                            write_op,
  input  logic [ihd_pkg::TAG_W-1:0]       done_tag,
  input  logic                            done_tracked,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            race,
  output logic                            tracked,
  output logic [ihd_pkg::TAG_W-1:0]       tag,
  output logic [ihd_pkg::SECTOR_BITS-1:0] mapped_sector
);
  import ihd_pkg::*;

  localparam lba_t SECTOR_MAX = {SECTOR_BITS{1'b1}};

  state_t state;
  state_t state_next;

  // Configured offset.
  lba_t sector_offset;

  // Valid bit per slot, in flip-flops so reset clears the table at once.
  logic [TABLE_DEPTH-1:0] valid;

  // Captured request.
  logic                 req_mode;
  logic                 req_wr;
  logic [COUNT_W-1:0]   req_count;
  lba_t                 req_first;
  lba_t                 req_final;

  // Result waiting for the output register.
  logic                 p_race;
  logic                 p_tracked;
  logic [TAG_W-1:0]     p_tag;

  // Handshake and control strobes.
  logic                 in_accept;
  logic                 out_free;
  logic                 load_out;
  logic                 scan_start;
  logic                 scan_end;

  // Complete-tag decode.
  logic [IDX_W+TAG_W-1:0] done_wide;
  logic                   done_in_range;
  idx_t                   done_idx;

  // Range end with saturation at the top sector.
  logic [COUNT_W-1:0]     count_m1;
  logic [SECTOR_BITS:0]   end_sum;
  lba_t                   final_calc;

  // Slot tag conversion.
  logic [IDX_W+TAG_W-1:0] slot_wide;

  // Table RAM and scan engine.
  scan_req_t              sreq;
  scan_res_t              sres;
  idx_t                   ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign done_wide     = {{IDX_W{1'b0}}, done_tag};
  assign done_in_range = done_wide < (IDX_W + TAG_W)'(TABLE_DEPTH);
  assign done_idx      = done_wide[IDX_W-1:0];

  // Overflow of first + count - 1 past the top sector shows as the carry.
  assign count_m1   = req_count - COUNT_W'(1);
  assign end_sum    = {1'b0, req_first} + {{(SECTOR_BITS + 1 - COUNT_W){1'b0}}, count_m1};
  assign final_calc = end_sum[SECTOR_BITS] ? SECTOR_MAX : end_sum[SECTOR_BITS-1:0];

  assign slot_wide = {{TAG_W{1'b0}}, sres.slot};

  // Store the new request once the scan found a free slot.
  assign ram_we    = scan_end && sres.found;
  assign ram_wdata = {req_first, req_final, req_wr};

  assign sreq = '{start: scan_start, first: req_first, final_sector: req_final,
                  wr: req_wr};

  ihd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sres.slot),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ihd_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .req   (sreq),
    .valid (valid),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .res   (sres)
  );

  // Next state and strobes.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    scan_start = 1'b0;
    scan_end   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (mode == MODE_COMPLETE) ? S_FINISH : S_PREP;
        end
      end
      S_PREP: begin
        // A zero-length request skips the table entirely.
        if (req_count == '0) begin
          state_next = S_FINISH;
        end else begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sres.done) begin
          scan_end   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_offset <= '0;
      valid         <= '0;
    end else begin
      if (cfg_we) begin
        sector_offset <= cfg_wdata;
      end
      // Drop a slot on a complete that names a tracked, in-range tag.
      if (in_accept && mode == MODE_COMPLETE && done_tracked && done_in_range) begin
        valid[done_idx] <= 1'b0;
      end
      if (ram_we) begin
        valid[sres.slot] <= 1'b1;
      end
    end
  end

  // Capture the request and build the pending result.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode  <= mode;
      req_wr    <= write_op;
      req_count <= sector_count;
      req_first <= start_sector + sector_offset;
      p_race    <= 1'b0;
      p_tracked <= 1'b0;
      p_tag     <= '0;
    end
    if (state == S_PREP) begin
      req_final <= final_calc;
    end
    if (scan_end) begin
      // A full table leaves the request unchecked.
      p_race    <= sres.found && sres.race;
      p_tracked <= sres.found;
      p_tag     <= sres.found ? slot_wide[TAG_W-1:0] : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      race          <= p_race;
      tracked       <= p_tracked;
      tag           <= p_tag;
      mapped_sector <= (req_mode == MODE_COMPLETE) ? '0 : req_first;
    end
  end

  // Checks.
  a_done_in_scan : assert property (@(posedge clk) disable iff (rst)
    sres.done |-> state == S_SCAN)
    else $error("scan finished outside the scan state");

  a_store_free_slot : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !valid[sres.slot])
    else $error("request stored over a busy slot");

  a_store_marks_valid : assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(sres.slot)])
    else $error("stored slot not marked valid");

  a_load_only_when_free : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load_out)
    else $error("result overwritten while stalled");

endmodule

### rtl/ihd_ram.sv
// ----------------------------------------------------------------------------
// ihd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ihd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ihd_scan.sv
// ----------------------------------------------------------------------------
// ihd_scan
// Table scan engine: walks every slot, one per cycle, flags an overlap with
// the new range where either side writes, and finds the lowest free slot.
// ----------------------------------------------------------------------------
module ihd_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  ihd_pkg::scan_req_t                  req,
  input  logic [ihd_pkg::TABLE_DEPTH-1:0]     valid,
  output ihd_pkg::idx_t                       raddr,
  input  logic [ihd_pkg::ENTRY_W-1:0]         rdata,
  output ihd_pkg::scan_res_t                  res
);
  import ihd_pkg::*;

  localparam idx_t LAST = IDX_W'(TABLE_DEPTH - 1);

  logic    active;
  logic    pend;
  logic    done;
  logic    race;
  logic    found;
  idx_t    cnt;
  idx_t    pidx;
  idx_t    slot;
  lba_t    e_first;
  lba_t    e_final;
  logic    e_wr;
  logic    hit;

  assign e_first = rdata[ENTRY_W-1 -: SECTOR_BITS];
  assign e_final = rdata[SECTOR_BITS:1];
  assign e_wr    = rdata[0];

  assign hit = (e_first <= req.final_sector) && (req.first <= e_final) &&
               (e_wr || req.wr);

  assign raddr = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
      done   <= 1'b0;
      race   <= 1'b0;
      found  <= 1'b0;
    end else begin
      done <= pend && (pidx == LAST);
      pend <= active;
      if (req.start) begin
        active <= 1'b1;
        race   <= 1'b0;
        found  <= 1'b0;
      end else begin
        if (active && cnt == LAST) begin
          active <= 1'b0;
        end
        if (pend) begin
          if (valid[pidx]) begin
            race <= race | hit;
          end else if (!found) begin
            found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt;
    if (req.start) begin
      cnt <= '0;
    end else if (active) begin
      cnt <= cnt + IDX_W'(1);
    end
    if (!req.start && pend && !valid[pidx] && !found) begin
      slot <= pidx;
    end
  end

  assign res = '{done: done, race: race, found: found, slot: slot};

endmodule
